// ===== rtl/pwmog_pkg.sv =====
// Shared types, codes and the action-resolution function of the PWM action generator.
`default_nettype none

package pwmog_pkg;

  localparam int NumOps     = 3;
  localparam int MaskW      = 3;
  localparam int CountW     = 16;
  localparam int ActW       = 8;
  localparam int PrescW     = 8;
  localparam int LimW       = 17;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  localparam logic [CountW-1:0] PeriodReset = 16'd999;
  localparam logic [ActW-1:0]   ActReset    = 8'h01;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_WR_CMP_A  = 3'd1,
    OP_WR_CMP_B  = 3'd2,
    OP_WR_ACT_A  = 3'd3,
    OP_WR_ACT_B  = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLOCK_PRESCALE  = 3'd0,
    CFG_TIMER_PRESCALE  = 3'd1,
    CFG_TIMER_PERIOD    = 3'd2,
    CFG_CMP_A_LATCH     = 3'd3,
    CFG_CMP_B_LATCH     = 3'd4,
    CFG_TIMERS_RUNNING  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_LOW    = 2'd1,
    ACT_HIGH   = 2'd2,
    ACT_TOGGLE = 2'd3
  } act_e;

  typedef struct packed {
    logic [2:0]        op;
    logic [1:0]        operator_index;
    logic [CountW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [MaskW-1:0] level_a_mask;
    logic [MaskW-1:0] level_b_mask;
    logic [MaskW-1:0] zero_event_mask;
  } out_item_t;

  typedef struct packed {
    logic              advance;
    logic              wr_cmp_a;
    logic              wr_cmp_b;
    logic              wr_act_a;
    logic              wr_act_b;
    logic              latch_a;
    logic              latch_b;
    logic [CountW-1:0] value;
    logic [CountW-1:0] period;
  } op_ctrl_t;

  // Event bits: 0 zero, 1 period, 2 compare A, 3 compare B. Highest set event
  // with a real action wins.
  function automatic logic gen_next(input logic level, input logic [ActW-1:0] word,
                                    input logic [3:0] ev);
    logic       res;
    logic       done;
    logic [1:0] code;
    res  = level;
    done = 1'b0;
    for (int e = 3; e >= 0; e--) begin
      code = word[2*e +: 2];
      if (!done && ev[e] && (code != ACT_NONE)) begin
        done = 1'b1;
        case (act_e'(code))
          ACT_LOW:    res = 1'b0;
          ACT_HIGH:   res = 1'b1;
          ACT_TOGGLE: res = ~level;
          default:    res = level;
        endcase
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pwm_operator_action_generator.sv =====
// Top level: input register, shared prescaler, operators and result register.
//
//   channel | signals                          | direction
//   in      | in_valid_i, in_stall_o, in_item_i   | item in (tick or write)
//   out     | out_valid_o, out_stall_i, out_item_o | levels and zero events
//   cfg     | cfg_wr_en_i, cfg_index_i, cfg_data_i | register write
//
// One item per cycle unless the result stalls; the result register offers each result.
// The operator timers, compares and generator update all sit between the input
// register and the result register; the divider limit is a small prescaler product.
// Reset is asynchronous and active low; it restores all register reset values.
// A stalled result holds the input register, which then stalls the input side.
`default_nettype none

module pwm_operator_action_generator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire pwmog_pkg::in_item_t                in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output pwmog_pkg::out_item_t                    out_item_o,
  input  wire logic                               cfg_wr_en_i,
  input  wire logic [pwmog_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [pwmog_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int N = pwmog_pkg::NumOps;

  logic [pwmog_pkg::PrescW-1:0] clk_presc_q, tmr_presc_q;
  logic [pwmog_pkg::CountW-1:0] period_q;
  logic                         latch_a_q, latch_b_q, running_q;
  logic [pwmog_pkg::LimW-1:0]   lim;
  logic [pwmog_pkg::CountW-1:0] div_q;
  logic [pwmog_pkg::LimW-1:0]   div_inc;

  logic                         in_valid_q;
  pwmog_pkg::in_item_t          in_q;
  logic                         out_valid_q;
  pwmog_pkg::out_item_t         out_item_q, out_item_d;

  logic                         adv;
  logic                         is_tick;
  logic                         tmr_adv;
  logic                         idx_ok;

  pwmog_pkg::op_ctrl_t          ctrl [N];
  logic [N-1:0]                 lvl_a, lvl_b, zero;

  // Move the input register into the result register.
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  assign is_tick = (pwmog_pkg::op_e'(in_q.op) == pwmog_pkg::OP_TICK);
  assign lim     = ({9'd0, clk_presc_q} + 17'd1) * ({9'd0, tmr_presc_q} + 17'd1);
  assign div_inc = {1'b0, div_q} + 17'd1;
  assign tmr_adv = adv && is_tick && running_q && (div_inc >= lim);
  assign idx_ok  = (32'(in_q.operator_index) < N);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_presc_q <= '0;
      tmr_presc_q <= '0;
      period_q    <= pwmog_pkg::PeriodReset;
      latch_a_q   <= 1'b1;
      latch_b_q   <= 1'b1;
      running_q   <= 1'b0;
      div_q       <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        case (pwmog_pkg::cfg_idx_e'(cfg_index_i))
          pwmog_pkg::CFG_CLOCK_PRESCALE: clk_presc_q <= cfg_data_i[pwmog_pkg::PrescW-1:0];
          pwmog_pkg::CFG_TIMER_PRESCALE: tmr_presc_q <= cfg_data_i[pwmog_pkg::PrescW-1:0];
          pwmog_pkg::CFG_TIMER_PERIOD:   period_q    <= cfg_data_i;
          pwmog_pkg::CFG_CMP_A_LATCH:    latch_a_q   <= cfg_data_i[0];
          pwmog_pkg::CFG_CMP_B_LATCH:    latch_b_q   <= cfg_data_i[0];
          pwmog_pkg::CFG_TIMERS_RUNNING: running_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (adv && is_tick && running_q) begin
        div_q <= (div_inc >= lim) ? '0 : div_inc[pwmog_pkg::CountW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_op
    logic sel;
    assign sel = adv && idx_ok && (32'(in_q.operator_index) == i);
    always_comb begin
      ctrl[i].advance  = tmr_adv;
      ctrl[i].wr_cmp_a = sel && (pwmog_pkg::op_e'(in_q.op) == pwmog_pkg::OP_WR_CMP_A);
      ctrl[i].wr_cmp_b = sel && (pwmog_pkg::op_e'(in_q.op) == pwmog_pkg::OP_WR_CMP_B);
      ctrl[i].wr_act_a = sel && (pwmog_pkg::op_e'(in_q.op) == pwmog_pkg::OP_WR_ACT_A);
      ctrl[i].wr_act_b = sel && (pwmog_pkg::op_e'(in_q.op) == pwmog_pkg::OP_WR_ACT_B);
      ctrl[i].latch_a  = latch_a_q;
      ctrl[i].latch_b  = latch_b_q;
      ctrl[i].value    = in_q.value;
      ctrl[i].period   = period_q;
    end

    pwmog_operator u_op (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[i]),
      .level_a_o (lvl_a[i]),
      .level_b_o (lvl_b[i]),
      .zero_o    (zero[i])
    );
  end

  // Each mask bit shows the operator of its index; bits with no operator read zero.
  for (genvar j = 0; j < pwmog_pkg::MaskW; j++) begin : g_mask
    if (j < N) begin : g_on
      assign out_item_d.level_a_mask[j]    = lvl_a[j];
      assign out_item_d.level_b_mask[j]    = lvl_b[j];
      assign out_item_d.zero_event_mask[j] = zero[j];
    end else begin : g_off
      assign out_item_d.level_a_mask[j]    = 1'b0;
      assign out_item_d.level_b_mask[j]    = 1'b0;
      assign out_item_d.zero_event_mask[j] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_zero_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !is_tick |=> out_item_q.zero_event_mask == '0)
    else $error("zero event reported for a write beat");

  a_zero_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !running_q |=> out_item_q.zero_event_mask == '0)
    else $error("zero event reported while timers stopped");

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// ===== rtl/pwmog_operator.sv =====
// One operator: up-counting timer, shadowed compares, action words and two generators.
`default_nettype none

module pwmog_operator (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pwmog_pkg::op_ctrl_t         ctrl_i,
  output logic                             level_a_o,
  output logic                             level_b_o,
  output logic                             zero_o
);

  logic [pwmog_pkg::CountW-1:0] timer_q, timer_d;
  logic [pwmog_pkg::CountW-1:0] shadow_a_q, shadow_b_q;
  logic [pwmog_pkg::CountW-1:0] active_a_q, active_b_q;
  logic [pwmog_pkg::CountW-1:0] cmp_a_eff, cmp_b_eff;
  logic [pwmog_pkg::ActW-1:0]   act_a_q, act_b_q;
  logic                         level_a_q, level_b_q;
  logic                         level_a_d, level_b_d;
  logic [3:0]                   ev;

  assign timer_d = (timer_q >= ctrl_i.period) ? '0 : timer_q + 16'd1;

  // With latching at zero set, the shadow goes active at zero before the compare is checked.
  assign cmp_a_eff = (timer_d == '0 && ctrl_i.latch_a) ? shadow_a_q : active_a_q;
  assign cmp_b_eff = (timer_d == '0 && ctrl_i.latch_b) ? shadow_b_q : active_b_q;

  assign ev[0] = (timer_d == '0);
  assign ev[1] = (timer_d == ctrl_i.period);
  assign ev[2] = (timer_d == cmp_a_eff);
  assign ev[3] = (timer_d == cmp_b_eff);

  always_comb begin
    level_a_d = level_a_q;
    level_b_d = level_b_q;
    if (ctrl_i.advance) begin
      level_a_d = pwmog_pkg::gen_next(level_a_q, act_a_q, ev);
      level_b_d = pwmog_pkg::gen_next(level_b_q, act_b_q, ev);
    end
  end

  assign level_a_o = level_a_d;
  assign level_b_o = level_b_d;
  assign zero_o    = ctrl_i.advance & ev[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q    <= '0;
      shadow_a_q <= '0;
      shadow_b_q <= '0;
      active_a_q <= '0;
      active_b_q <= '0;
      act_a_q    <= pwmog_pkg::ActReset;
      act_b_q    <= pwmog_pkg::ActReset;
      level_a_q  <= 1'b0;
      level_b_q  <= 1'b0;
    end else begin
      level_a_q <= level_a_d;
      level_b_q <= level_b_d;
      if (ctrl_i.advance) begin
        timer_q <= timer_d;
        active_a_q <= cmp_a_eff;
        active_b_q <= cmp_b_eff;
      end
      if (ctrl_i.wr_cmp_a) begin
        shadow_a_q <= ctrl_i.value;
        if (!ctrl_i.latch_a) begin
          active_a_q <= ctrl_i.value;
        end
      end
      if (ctrl_i.wr_cmp_b) begin
        shadow_b_q <= ctrl_i.value;
        if (!ctrl_i.latch_b) begin
          active_b_q <= ctrl_i.value;
        end
      end
      if (ctrl_i.wr_act_a) begin
        act_a_q <= ctrl_i.value[pwmog_pkg::ActW-1:0];
      end
      if (ctrl_i.wr_act_b) begin
        act_b_q <= ctrl_i.value[pwmog_pkg::ActW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== bench/pwmog_checker.sv =====
`timescale 1ns / 100ps
// Watches the item, result and register ports of the PWM action generator and checks each result.
module pwmog_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  pwmog_pkg::in_item_t            in_item_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  pwmog_pkg::out_item_t           out_item_i,
  input  logic                           cfg_wr_en_i,
  input  logic [pwmog_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pwmog_pkg::CfgDataW-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  logic [pwmog_pkg::PrescW-1:0] clk_presc;
  logic [pwmog_pkg::PrescW-1:0] tmr_presc;
  logic [pwmog_pkg::CountW-1:0] period;
  logic                         latch_a_at_zero;
  logic                         latch_b_at_zero;
  logic                         running;

  int unsigned                  div_cnt;
  logic [pwmog_pkg::CountW-1:0] tmr_cnt    [pwmog_pkg::NumOps];
  logic [pwmog_pkg::CountW-1:0] shd_cmp_a  [pwmog_pkg::NumOps];
  logic [pwmog_pkg::CountW-1:0] shd_cmp_b  [pwmog_pkg::NumOps];
  logic [pwmog_pkg::CountW-1:0] act_cmp_a  [pwmog_pkg::NumOps];
  logic [pwmog_pkg::CountW-1:0] act_cmp_b  [pwmog_pkg::NumOps];
  logic [pwmog_pkg::ActW-1:0]   act_word_a [pwmog_pkg::NumOps];
  logic [pwmog_pkg::ActW-1:0]   act_word_b [pwmog_pkg::NumOps];
  logic                         lvl_a      [pwmog_pkg::NumOps];
  logic                         lvl_b      [pwmog_pkg::NumOps];

  pwmog_pkg::out_item_t expected_levels_q[$];
  pwmog_pkg::out_item_t want;

  // Scan events from zero up; a later event with a real action overrides.
  function automatic logic resolve_level(input logic cur,
                                         input logic [pwmog_pkg::ActW-1:0] word,
                                         input logic [3:0] hits);
    logic [1:0] code;
    code = pwmog_pkg::ACT_NONE;
    for (int e = 0; e < 4; e++) begin
      if (hits[e] && (word[2*e +: 2] != pwmog_pkg::ACT_NONE)) code = word[2*e +: 2];
    end
    case (code)
      pwmog_pkg::ACT_LOW:    return 1'b0;
      pwmog_pkg::ACT_HIGH:   return 1'b1;
      pwmog_pkg::ACT_TOGGLE: return ~cur;
      default:               return cur;
    endcase
  endfunction

  function automatic pwmog_pkg::out_item_t predict_levels(input pwmog_pkg::in_item_t it);
    pwmog_pkg::out_item_t res;
    logic [3:0]           hits;
    logic                 step;
    int unsigned          div_lim;
    res  = '0;
    step = 1'b0;
    if (it.op == pwmog_pkg::OP_TICK) begin
      if (running) begin
        div_lim = (int'(clk_presc) + 1) * (int'(tmr_presc) + 1);
        if (div_cnt + 1 >= div_lim) begin
          div_cnt = 0;
          step    = 1'b1;
        end else begin
          div_cnt = div_cnt + 1;
        end
      end
      if (step) begin
        for (int i = 0; i < pwmog_pkg::NumOps; i++) begin
          tmr_cnt[i] = (tmr_cnt[i] >= period) ? '0 : tmr_cnt[i] + 1'b1;
          hits = '0;
          if (tmr_cnt[i] == '0) begin
            // latch pending shadows before the compares are checked
            hits[0] = 1'b1;
            if (i < pwmog_pkg::MaskW) res.zero_event_mask[i] = 1'b1;
            if (latch_a_at_zero) act_cmp_a[i] = shd_cmp_a[i];
            if (latch_b_at_zero) act_cmp_b[i] = shd_cmp_b[i];
          end
          if (tmr_cnt[i] == period)       hits[1] = 1'b1;
          if (tmr_cnt[i] == act_cmp_a[i]) hits[2] = 1'b1;
          if (tmr_cnt[i] == act_cmp_b[i]) hits[3] = 1'b1;
          lvl_a[i] = resolve_level(lvl_a[i], act_word_a[i], hits);
          lvl_b[i] = resolve_level(lvl_b[i], act_word_b[i], hits);
        end
      end
    end else if (it.operator_index < pwmog_pkg::NumOps) begin
      case (it.op)
        pwmog_pkg::OP_WR_CMP_A: begin
          shd_cmp_a[it.operator_index] = it.value;
          if (!latch_a_at_zero) act_cmp_a[it.operator_index] = it.value;
        end
        pwmog_pkg::OP_WR_CMP_B: begin
          shd_cmp_b[it.operator_index] = it.value;
          if (!latch_b_at_zero) act_cmp_b[it.operator_index] = it.value;
        end
        pwmog_pkg::OP_WR_ACT_A: act_word_a[it.operator_index] = it.value[pwmog_pkg::ActW-1:0];
        pwmog_pkg::OP_WR_ACT_B: act_word_b[it.operator_index] = it.value[pwmog_pkg::ActW-1:0];
        default: ;
      endcase
    end
    for (int i = 0; i < pwmog_pkg::NumOps && i < pwmog_pkg::MaskW; i++) begin
      res.level_a_mask[i] = lvl_a[i];
      res.level_b_mask[i] = lvl_b[i];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_presc       = '0;
      tmr_presc       = '0;
      period          = pwmog_pkg::PeriodReset;
      latch_a_at_zero = 1'b1;
      latch_b_at_zero = 1'b1;
      running         = 1'b0;
      div_cnt         = 0;
      for (int i = 0; i < pwmog_pkg::NumOps; i++) begin
        tmr_cnt[i]    = '0;
        shd_cmp_a[i]  = '0;
        shd_cmp_b[i]  = '0;
        act_cmp_a[i]  = '0;
        act_cmp_b[i]  = '0;
        act_word_a[i] = pwmog_pkg::ActReset;
        act_word_b[i] = pwmog_pkg::ActReset;
        lvl_a[i]      = 1'b0;
        lvl_b[i]      = 1'b0;
      end
      expected_levels_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_wr_en_i) begin
        case (cfg_index_i)
          pwmog_pkg::CFG_CLOCK_PRESCALE: clk_presc       = cfg_data_i[pwmog_pkg::PrescW-1:0];
          pwmog_pkg::CFG_TIMER_PRESCALE: tmr_presc       = cfg_data_i[pwmog_pkg::PrescW-1:0];
          pwmog_pkg::CFG_TIMER_PERIOD:   period          = cfg_data_i[pwmog_pkg::CountW-1:0];
          pwmog_pkg::CFG_CMP_A_LATCH:    latch_a_at_zero = cfg_data_i[0];
          pwmog_pkg::CFG_CMP_B_LATCH:    latch_b_at_zero = cfg_data_i[0];
          pwmog_pkg::CFG_TIMERS_RUNNING: running         = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_levels_q.push_back(predict_levels(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_levels_q.size() == 0) begin
          $error("result beat with no expected levels waiting: %p", out_item_i);
          fail_count_o++;
        end else begin
          want = expected_levels_q.pop_front();
          if (out_item_i.level_a_mask !== want.level_a_mask) begin
            $error("level_a_mask: expected %0h, actual %0h",
                   want.level_a_mask, out_item_i.level_a_mask);
            fail_count_o++;
          end
          if (out_item_i.level_b_mask !== want.level_b_mask) begin
            $error("level_b_mask: expected %0h, actual %0h",
                   want.level_b_mask, out_item_i.level_b_mask);
            fail_count_o++;
          end
          if (out_item_i.zero_event_mask !== want.zero_event_mask) begin
            $error("zero_event_mask: expected %0h, actual %0h",
                   want.zero_event_mask, out_item_i.zero_event_mask);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_levels_q.size();
    end
  end

endmodule

// ===== bench/tb_pwm_operator_action_generator.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, item and register stimulus, and the final verdict.
module tb_pwm_operator_action_generator;

  localparam int             CycleLimit = 200000;
  localparam logic [2:0]     OpUnusedLo = 3'd5;
  localparam logic [2:0]     OpUnusedHi = 3'd7;
  localparam logic [1:0]     NoOperator = 2'(pwmog_pkg::NumOps);

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  pwmog_pkg::in_item_t            in_item   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  pwmog_pkg::out_item_t           out_item;
  logic                           cfg_wr_en = 1'b0;
  logic [pwmog_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [pwmog_pkg::CfgDataW-1:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int cycle_cnt    = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int cur_period   = int'(pwmog_pkg::PeriodReset);

  pwm_operator_action_generator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_wr_en_i (cfg_wr_en),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  pwmog_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_wr_en_i  (cfg_wr_en),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  function automatic pwmog_pkg::in_item_t make_beat(input logic [2:0] op,
                                                    input logic [1:0] idx,
                                                    input logic [pwmog_pkg::CountW-1:0] val);
    pwmog_pkg::in_item_t it;
    it.op             = op;
    it.operator_index = idx;
    it.value          = val;
    return it;
  endfunction

  function automatic logic [pwmog_pkg::CountW-1:0] act_word(input pwmog_pkg::act_e z,
                                                            input pwmog_pkg::act_e p,
                                                            input pwmog_pkg::act_e a,
                                                            input pwmog_pkg::act_e b);
    return {8'h00, b, a, p, z};
  endfunction

  // Mostly ticks so the timers run, writes with compares mostly up to one past the timer's reach,
  // and a little noise: unused op codes and writes to no operator.
  function automatic pwmog_pkg::in_item_t random_item();
    pwmog_pkg::in_item_t it;
    int                  pick;
    int                  reach;
    pick  = $urandom_range(0, 99);
    reach = (cur_period < 300) ? cur_period : 300;
    it.operator_index = 2'($urandom_range(0, pwmog_pkg::NumOps - 1));
    it.value          = 16'($urandom);
    if (pick < 55) begin
      it.op             = pwmog_pkg::OP_TICK;
      it.operator_index = 2'($urandom_range(0, 3));
    end else if (pick < 95) begin
      it.op = 3'($urandom_range(pwmog_pkg::OP_WR_CMP_A, pwmog_pkg::OP_WR_ACT_B));
      if ((it.op == pwmog_pkg::OP_WR_CMP_A || it.op == pwmog_pkg::OP_WR_CMP_B) &&
          $urandom_range(0, 9) < 8) begin
        it.value = 16'($urandom_range(0, reach + 1));
      end
    end else begin
      it.op = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 1) it.operator_index = NoOperator;
    end
    return it;
  endfunction

  // Hold the beat until the block takes it.
  task automatic send_beat(input pwmog_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input pwmog_pkg::cfg_idx_e idx, input int val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= pwmog_pkg::CfgDataW'(val);
  endtask

  task automatic write_settings(input int cp, input int tp, input int per,
                                input int la, input int lb, input int run);
    wait_drained();
    write_reg(pwmog_pkg::CFG_CLOCK_PRESCALE, cp);
    write_reg(pwmog_pkg::CFG_TIMER_PRESCALE, tp);
    write_reg(pwmog_pkg::CFG_TIMER_PERIOD, per);
    write_reg(pwmog_pkg::CFG_CMP_A_LATCH, la);
    write_reg(pwmog_pkg::CFG_CMP_B_LATCH, lb);
    write_reg(pwmog_pkg::CFG_TIMERS_RUNNING, run);
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    cur_period  = per;
  endtask

  task automatic run_phase(input int cp, input int tp, input int per, input int la,
                           input int lb, input int run, input int n_beats);
    write_settings(cp, tp, per, la, lb, run);
    repeat (n_beats) send_beat(random_item());
  endtask

  initial begin
    snd_idle_pct = 12;
    rcv_idle_pct = 76;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Timers stopped after reset: ticks change nothing; action word keeps low 8 bits.
    send_beat(make_beat(pwmog_pkg::OP_TICK, NoOperator, 16'hFFFF));
    send_beat(make_beat(pwmog_pkg::OP_WR_ACT_A, 2'd0, 16'hFFFF));
    send_beat(make_beat(pwmog_pkg::OP_TICK, 2'd0, 16'h0000));

    write_settings(0, 0, 3, 1, 0, 1);
    send_beat(make_beat(pwmog_pkg::OP_WR_CMP_A, 2'd0, 16'd2));
    // compare B on the period count: coinciding events, compare B wins
    send_beat(make_beat(pwmog_pkg::OP_WR_CMP_B, 2'd0, 16'd3));
    send_beat(make_beat(pwmog_pkg::OP_WR_ACT_B, 2'd0,
                        act_word(pwmog_pkg::ACT_LOW, pwmog_pkg::ACT_TOGGLE,
                                 pwmog_pkg::ACT_LOW, pwmog_pkg::ACT_HIGH)));
    // compares beyond the period never fire
    send_beat(make_beat(pwmog_pkg::OP_WR_ACT_A, 2'd1,
                        act_word(pwmog_pkg::ACT_HIGH, pwmog_pkg::ACT_NONE,
                                 pwmog_pkg::ACT_LOW, pwmog_pkg::ACT_TOGGLE)));
    send_beat(make_beat(pwmog_pkg::OP_WR_CMP_A, 2'd1, 16'd9));
    send_beat(make_beat(pwmog_pkg::OP_WR_CMP_B, 2'd1, 16'hFFFF));
    // compare B with no action gives way to compare A on the same count
    send_beat(make_beat(pwmog_pkg::OP_WR_ACT_A, 2'd2,
                        act_word(pwmog_pkg::ACT_LOW, pwmog_pkg::ACT_NONE,
                                 pwmog_pkg::ACT_HIGH, pwmog_pkg::ACT_NONE)));
    send_beat(make_beat(pwmog_pkg::OP_WR_CMP_A, 2'd2, 16'd1));
    send_beat(make_beat(pwmog_pkg::OP_WR_CMP_B, 2'd2, 16'd1));
    // ignored writes
    send_beat(make_beat(pwmog_pkg::OP_WR_CMP_A, NoOperator, 16'd0));
    send_beat(make_beat(OpUnusedLo, 2'd0, 16'h5555));
    send_beat(make_beat(OpUnusedHi, 2'd1, 16'hAAAA));
    repeat (9) send_beat(make_beat(pwmog_pkg::OP_TICK, 2'd0, 16'h0000));

    run_phase(0, 0, 7, 1, 1, 1, 200);
    run_phase(1, 2, 20, 0, 1, 1, 200);
    run_phase(0, 0, 0, 1, 0, 1, 150);

    snd_idle_pct = 76;
    rcv_idle_pct = 12;
    run_phase(255, 0, 5, 0, 0, 1, 150);
    // divider well past the new limit: next tick ends the division
    run_phase(0, 0, 65535, 1, 1, 1, 200);
    run_phase(3, 0, 12, 1, 1, 0, 100);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_phase(0, 255, 4, 0, 1, 1, 150);
    run_phase(255, 255, 9, 1, 1, 1, 30);
    run_phase(0, 1, 15, 1, 0, 1, 300);
    run_phase(0, 0, 3, 0, 0, 1, 120);

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
